>>> rtl/core/touch_point_calibration_map_defines.svh
//------------------------------------------------------------------------------
// Touch point calibration map: assertion macros
// Shared assertion wrappers, clocked on aclk and disabled while aresetn is low.
//------------------------------------------------------------------------------
`ifndef TOUCH_POINT_CALIBRATION_MAP_DEFINES_SVH
`define TOUCH_POINT_CALIBRATION_MAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TPCM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TPCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tpcm_pkg.sv
//------------------------------------------------------------------------------
// Touch point calibration map: package
// Widths, register indexes, defaults and the sequencer state type.
//------------------------------------------------------------------------------
package tpcm_pkg;

    // Default screen size in pixels.
    localparam int DEF_SCREEN_W = 1024;
    localparam int DEF_SCREEN_H = 600;

    // Field widths.
    localparam int RAW_W      = 12;
    localparam int SIZE_W     = 12;
    localparam int SPAN_W     = 13;
    localparam int DIFF_W     = 13;
    localparam int PROD_W     = RAW_W + SIZE_W;
    localparam int QUOT_W     = PROD_W + 2;
    localparam int CNT_W      = $clog2(PROD_W);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_TDATA_W = 24;
    localparam int IN_TUSER_W = 3;

    // Input tuser bit positions.
    localparam int TUSER_MODE       = 0;
    localparam int TUSER_RESISTIVE  = 1;
    localparam int TUSER_SUPPRESSED = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_SWAP_AXES = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAN_X    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_SPAN_Y    = 3'd4;

    // Register reset values.
    localparam logic [RAW_W-1:0]  CENTER_RESET = 12'd2048;
    localparam logic [SPAN_W-1:0] SPAN_RESET   = 13'd4095;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/touch_point_calibration_map.sv
//------------------------------------------------------------------------------
// Touch point calibration map
// Maps raw touch samples to clamped screen coordinates with a two point
// linear calibration, one shared serial divider for both axes.
//------------------------------------------------------------------------------
// A resistive sample is accepted and then worked on alone: each axis takes a
// multiply step, a 24-bit pass of the shared restoring divider (one quotient
// bit a cycle) and a finish step, and the ST_OUT state then loads the output
// register once it is free; the input is ready again once that result is
// loaded into the output register. A capacitive sample goes from ST_IDLE
// straight to ST_OUT. Backlight off events and suppressed samples leave the
// sequencer idle and give no result. The input side stays ready while a
// finished result waits to be taken; the user must see that configuration is
// written through the plain write port while idle; the block does not enforce it.
//------------------------------------------------------------------------------
`include "touch_point_calibration_map_defines.svh"

module touch_point_calibration_map #(
    parameter int SCREEN_W = tpcm_pkg::DEF_SCREEN_W,
    parameter int SCREEN_H = tpcm_pkg::DEF_SCREEN_H,
    localparam int XW      = $clog2(SCREEN_W + 1),
    localparam int YW      = $clog2(SCREEN_H + 1),
    localparam int OUT_W   = ((XW + YW + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port.
    input  logic                            cfg_wr_en,
    input  logic [tpcm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tpcm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input sample stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tpcm_pkg::IN_TDATA_W-1:0] s_tdata,  // raw_a, raw_b
    input  logic [tpcm_pkg::IN_TUSER_W-1:0] s_tuser,  // mode, resistive, suppressed
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [OUT_W-1:0]                m_tdata,  // screen_x, screen_y
    output logic                            m_tuser   // wake_only
);

    localparam int RW = tpcm_pkg::RAW_W;
    localparam int SW = tpcm_pkg::SIZE_W;
    localparam int PW = tpcm_pkg::PROD_W;
    localparam int QW = tpcm_pkg::QUOT_W;
    localparam int NW = tpcm_pkg::SPAN_W;
    localparam int CW = tpcm_pkg::CNT_W;

    localparam logic [SW-1:0] SIZE_X   = SW'(SCREEN_W);
    localparam logic [SW-1:0] SIZE_Y   = SW'(SCREEN_H);
    localparam logic [CW-1:0] LAST_CNT = CW'(PW - 1);

    // Configuration registers.
    logic          swap_reg;
    logic [RW-1:0] center_x_reg;
    logic [RW-1:0] center_y_reg;
    logic [NW-1:0] span_x_reg;
    logic [NW-1:0] span_y_reg;

    // Control state.
    tpcm_pkg::state_t state_reg, state_next;
    logic          axis_reg, axis_next;
    logic          backlight_reg, backlight_next;
    logic          m_valid_reg, m_valid_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Work registers.
    logic [RW-1:0] raw_x_reg, raw_x_next;
    logic [RW-1:0] raw_y_reg, raw_y_next;
    logic          wake_reg, wake_next;
    logic [XW-1:0] res_x_reg, res_x_next;
    logic [YW-1:0] res_y_reg, res_y_next;
    logic [PW-1:0] quo_reg, quo_next;
    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic          neg_reg, neg_next;

    // Output registers.
    logic [XW-1:0] out_x_reg, out_x_next;
    logic [YW-1:0] out_y_reg, out_y_next;
    logic          out_wake_reg, out_wake_next;

    // Input fields.
    logic          in_mode;
    logic          in_resistive;
    logic          in_suppressed;
    logic [RW-1:0] in_raw_a;
    logic [RW-1:0] in_raw_b;
    logic          in_fire;
    logic          out_free;

    // Datapath intermediates.
    logic [RW-1:0]                      raw_sel;
    logic [RW-1:0]                      center_sel;
    logic [NW-1:0]                      span_sel;
    logic [SW-1:0]                      size_sel;
    logic signed [tpcm_pkg::DIFF_W-1:0] diff;
    logic [RW-1:0]                      diff_mag;
    logic [NW-1:0]                      span_mag;
    logic [NW:0]                        trial;
    logic signed [QW-1:0]               quot_s;
    logic signed [QW-1:0]               val_s;
    logic [SW-1:0]                      clamped;

    assign in_raw_a      = s_tdata[RW-1:0];
    assign in_raw_b      = s_tdata[2*RW-1:RW];
    assign in_mode       = s_tuser[tpcm_pkg::TUSER_MODE];
    assign in_resistive  = s_tuser[tpcm_pkg::TUSER_RESISTIVE];
    assign in_suppressed = s_tuser[tpcm_pkg::TUSER_SUPPRESSED];

    assign s_tready = (state_reg == tpcm_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({out_y_reg, out_x_reg});
    assign m_tuser  = out_wake_reg;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tpcm_pkg::ST_IDLE: begin
                if (in_fire && !in_mode && !in_suppressed) begin
                    state_next = in_resistive ? tpcm_pkg::ST_MUL : tpcm_pkg::ST_OUT;
                end
            end
            tpcm_pkg::ST_MUL: begin
                state_next = tpcm_pkg::ST_DIV;
            end
            tpcm_pkg::ST_DIV: begin
                if (cnt_reg == LAST_CNT) begin
                    state_next = tpcm_pkg::ST_FIN;
                end
            end
            tpcm_pkg::ST_FIN: begin
                state_next = axis_reg ? tpcm_pkg::ST_OUT : tpcm_pkg::ST_MUL;
            end
            tpcm_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = tpcm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tpcm_pkg::ST_IDLE;
            end
        endcase
    end

    // Per-axis operand selection and the shared arithmetic.
    always_comb begin
        raw_sel    = axis_reg ? raw_y_reg : raw_x_reg;
        center_sel = axis_reg ? center_y_reg : center_x_reg;
        span_sel   = axis_reg ? span_y_reg : span_x_reg;
        size_sel   = axis_reg ? SIZE_Y : SIZE_X;

        diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, center_sel});
        diff_mag = diff[12] ? RW'(-diff) : RW'(diff);

        // A zero span is used as one; the most negative span has magnitude 4096.
        span_mag = span_sel[NW-1] ? (~span_sel + NW'(1)) : span_sel;
        if (span_sel == '0) begin
            span_mag = NW'(1);
        end

        // One restoring division step.
        trial = {rem_reg, quo_reg[PW-1]};

        // Signed quotient plus half the screen size, then clamp to 0..size.
        quot_s = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
        val_s  = quot_s + $signed({{(QW-SW){1'b0}}, (size_sel >> 1)});
        if (val_s[QW-1]) begin
            clamped = '0;
        end else if (val_s > $signed({{(QW-SW){1'b0}}, size_sel})) begin
            clamped = size_sel;
        end else begin
            clamped = val_s[SW-1:0];
        end
    end

    // Register updates for each state.
    always_comb begin
        axis_next      = axis_reg;
        backlight_next = backlight_reg;
        m_valid_next   = m_valid_reg;
        cnt_next       = cnt_reg;
        raw_x_next     = raw_x_reg;
        raw_y_next     = raw_y_reg;
        wake_next      = wake_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_wake_next  = out_wake_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tpcm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (in_mode) begin
                        backlight_next = 1'b0;
                    end else if (!in_suppressed) begin
                        wake_next      = !backlight_reg;
                        backlight_next = 1'b1;
                        axis_next      = 1'b0;
                        raw_x_next     = (in_resistive && swap_reg) ? in_raw_b : in_raw_a;
                        raw_y_next     = (in_resistive && swap_reg) ? in_raw_a : in_raw_b;
                        // Capacitive samples are only clamped.
                        res_x_next = (in_raw_a > RW'(SCREEN_W)) ? XW'(SCREEN_W)
                                                                : XW'(in_raw_a);
                        res_y_next = (in_raw_b > RW'(SCREEN_H)) ? YW'(SCREEN_H)
                                                                : YW'(in_raw_b);
                    end
                end
            end
            tpcm_pkg::ST_MUL: begin
                quo_next = PW'(diff_mag) * PW'(size_sel);
                rem_next = '0;
                den_next = span_mag;
                neg_next = diff[12] ^ span_sel[NW-1];
                cnt_next = '0;
            end
            tpcm_pkg::ST_DIV: begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_next = NW'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = trial[NW-1:0];
                    quo_next = {quo_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
            end
            tpcm_pkg::ST_FIN: begin
                if (axis_reg) begin
                    res_y_next = clamped[YW-1:0];
                end else begin
                    res_x_next = clamped[XW-1:0];
                end
                axis_next = 1'b1;
            end
            tpcm_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_x_next    = res_x_reg;
                    out_y_next    = res_y_reg;
                    out_wake_next = wake_reg;
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tpcm_pkg::ST_IDLE;
            axis_reg      <= 1'b0;
            backlight_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            backlight_reg <= backlight_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        raw_x_reg    <= raw_x_next;
        raw_y_reg    <= raw_y_next;
        wake_reg     <= wake_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        neg_reg      <= neg_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_wake_reg <= out_wake_next;
    end

    // Configuration registers; writes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swap_reg     <= 1'b0;
            center_x_reg <= tpcm_pkg::CENTER_RESET;
            center_y_reg <= tpcm_pkg::CENTER_RESET;
            span_x_reg   <= tpcm_pkg::SPAN_RESET;
            span_y_reg   <= tpcm_pkg::SPAN_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tpcm_pkg::REG_SWAP_AXES: swap_reg     <= cfg_wdata[0];
                tpcm_pkg::REG_CENTER_X:  center_x_reg <= cfg_wdata[RW-1:0];
                tpcm_pkg::REG_CENTER_Y:  center_y_reg <= cfg_wdata[RW-1:0];
                tpcm_pkg::REG_SPAN_X:    span_x_reg   <= cfg_wdata[NW-1:0];
                tpcm_pkg::REG_SPAN_Y:    span_y_reg   <= cfg_wdata[NW-1:0];
                default: begin
                    swap_reg <= swap_reg;
                end
            endcase
        end
    end

    // Assertions.
    `TPCM_ASSERT_SAME(a_x_in_range, m_valid_reg, out_x_reg <= XW'(SCREEN_W),
        "screen_x above screen width")
    `TPCM_ASSERT_SAME(a_y_in_range, m_valid_reg, out_y_reg <= YW'(SCREEN_H),
        "screen_y above screen height")
    `TPCM_ASSERT_SAME(a_rem_below_den, state_reg == tpcm_pkg::ST_DIV, rem_reg < den_reg,
        "divider remainder not below divisor")
    `TPCM_ASSERT_NEXT(a_backlight_off, in_fire && in_mode, !backlight_reg,
        "backlight still on after off event")
    `TPCM_ASSERT_NEXT(a_wake_sets_backlight, in_fire && !in_mode && !in_suppressed,
        backlight_reg && (wake_reg == !$past(backlight_reg)),
        "wake flag or backlight state wrong after touch")

endmodule
